>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the grid path sum block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// Grid path sum package
// Widths, register indexes, microcode types and the control program.
// ----------------------------------------------------------------------------
package gmps_pkg;

  // Field widths and default sizes.
  localparam int SUM_W         = 28;
  localparam int CELL_W        = 8;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int GMPS_MAX_COLS = 1024;
  localparam int GMPS_MAX_ROWS = 1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_RD_LEFT,
    OP_LEFT,
    OP_K_INIT,
    OP_C_RD,
    OP_C_WR,
    OP_R_RD,
    OP_R_SUM,
    OP_R_WR,
    OP_ROW_NEXT,
    OP_FINISH
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_NOT_ROW_END,
    C_LAST_ROW,
    C_NOT_FIRST,
    C_K_UP_MORE,
    C_K_DN_MORE
  } cond_t;

  typedef logic [3:0] step_t;

  // Program addresses.
  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_RD_LEFT = 4'd1;
  localparam step_t S_LEFT    = 4'd2;
  localparam step_t S_ROW_END = 4'd3;
  localparam step_t S_BRANCH  = 4'd4;
  localparam step_t S_C_RD    = 4'd5;
  localparam step_t S_C_WR    = 4'd6;
  localparam step_t S_C_NEXT  = 4'd7;
  localparam step_t S_R_RD    = 4'd8;
  localparam step_t S_R_SUM   = 4'd9;
  localparam step_t S_R_WR    = 4'd10;
  localparam step_t S_R_NEXT  = 4'd11;
  localparam step_t S_FINISH  = 4'd12;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Status flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic not_row_end;
    logic last_row;
    logic first_row;
    logic k_up_more;
    logic k_dn_more;
  } status_t;

  // Control store: the program that handles one cell and any row-end pass.
  function automatic ucode_t ucode_word(input step_t step);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    case (step)
      S_IDLE:    w = '{op: OP_IDLE,     cond: C_NO_START,    target: S_IDLE};
      S_RD_LEFT: w = '{op: OP_RD_LEFT,  cond: C_NEVER,       target: S_IDLE};
      S_LEFT:    w = '{op: OP_LEFT,     cond: C_NOT_ROW_END, target: S_IDLE};
      S_ROW_END: w = '{op: OP_K_INIT,   cond: C_LAST_ROW,    target: S_FINISH};
      S_BRANCH:  w = '{op: OP_NOP,      cond: C_NOT_FIRST,   target: S_R_RD};
      S_C_RD:    w = '{op: OP_C_RD,     cond: C_NEVER,       target: S_IDLE};
      S_C_WR:    w = '{op: OP_C_WR,     cond: C_K_UP_MORE,   target: S_C_RD};
      S_C_NEXT:  w = '{op: OP_ROW_NEXT, cond: C_ALWAYS,      target: S_IDLE};
      S_R_RD:    w = '{op: OP_R_RD,     cond: C_NEVER,       target: S_IDLE};
      S_R_SUM:   w = '{op: OP_R_SUM,    cond: C_NEVER,       target: S_IDLE};
      S_R_WR:    w = '{op: OP_R_WR,     cond: C_K_DN_MORE,   target: S_R_RD};
      S_R_NEXT:  w = '{op: OP_ROW_NEXT, cond: C_ALWAYS,      target: S_IDLE};
      S_FINISH:  w = '{op: OP_FINISH,   cond: C_ALWAYS,      target: S_IDLE};
      default:   w = '{op: OP_NOP,      cond: C_ALWAYS,      target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/gmps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gmps_useq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control store, with conditional jumps on status.
// ----------------------------------------------------------------------------
module gmps_useq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gmps_pkg::status_t status,
  output gmps_pkg::op_t     op,
  output logic             busy
);

  gmps_pkg::step_t  step;
  gmps_pkg::step_t  step_next;
  gmps_pkg::ucode_t word;
  logic             take;

  assign word = gmps_pkg::ucode_word(step);
  assign op   = word.op;
  assign busy = (step != gmps_pkg::S_IDLE);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    unique case (word.cond)
      gmps_pkg::C_NEVER:       take = 1'b0;
      gmps_pkg::C_ALWAYS:      take = 1'b1;
      gmps_pkg::C_NO_START:    take = !start;
      gmps_pkg::C_NOT_ROW_END: take = status.not_row_end;
      gmps_pkg::C_LAST_ROW:    take = status.last_row;
      gmps_pkg::C_NOT_FIRST:   take = !status.first_row;
      gmps_pkg::C_K_UP_MORE:   take = status.k_up_more;
      gmps_pkg::C_K_DN_MORE:   take = status.k_dn_more;
      default:                 take = 1'b1;
    endcase
  end

  assign step_next = take ? word.target : step + 4'd1;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= gmps_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/gmps_dp.sv
// ----------------------------------------------------------------------------
// Grid path sum datapath
// Row indexes, column stores and the adders and comparators that the
// control words drive.
// ----------------------------------------------------------------------------
module gmps_dp #(
  parameter int MAX_COLS = gmps_pkg::GMPS_MAX_COLS,
  parameter int MAX_ROWS = gmps_pkg::GMPS_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gmps_pkg::op_t                     op,
  input  logic                              start,
  input  logic signed [gmps_pkg::CELL_W-1:0] cell_value,
  input  logic [gmps_pkg::CFG_W-1:0]        row_count,
  input  logic [gmps_pkg::CFG_W-1:0]        column_count,
  output gmps_pkg::status_t                 status,
  output logic signed [gmps_pkg::SUM_W-1:0] best_sum,
  output logic                              done
);

  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int SW     = gmps_pkg::SUM_W;
  localparam int VW     = gmps_pkg::CELL_W;

  // Position in the grid.
  logic [RIDX_W-1:0] row_index;
  logic [CIDX_W-1:0] column_index;

  // Fields of the cell word at work.
  logic signed [VW-1:0] v_reg;
  logic [CIDX_W-1:0]    c_reg;
  logic [CIDX_W-1:0]    last_idx;
  logic                 row_end;
  logic                 last_row;
  logic                 first_row;
  logic [CIDX_W-1:0]    k;
  logic signed [SW-1:0] left_reg;
  logic signed [SW-1:0] right_reg;

  // Effective counts and the clamped column of an incoming word.
  logic [CCNT_W-1:0] eff_cols;
  logic [RCNT_W-1:0] eff_rows;
  logic [CIDX_W-1:0] c_in;
  logic              accept;

  always_comb begin
    if (column_count == '0) begin
      eff_cols = CCNT_W'(1);
    end else if (32'(column_count) > 32'(MAX_COLS)) begin
      eff_cols = CCNT_W'(MAX_COLS);
    end else begin
      eff_cols = CCNT_W'(column_count);
    end
    if (row_count == '0) begin
      eff_rows = RCNT_W'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      eff_rows = RCNT_W'(MAX_ROWS);
    end else begin
      eff_rows = RCNT_W'(row_count);
    end
  end

  assign c_in   = (CCNT_W'(column_index) >= eff_cols) ? CIDX_W'(eff_cols - CCNT_W'(1))
                                                      : column_index;
  assign accept = (op == gmps_pkg::OP_IDLE) && start;

  // Column store ports.
  logic              cells_we;
  logic [VW-1:0]     cells_rdata;
  logic              lp_we;
  logic [CIDX_W-1:0] lp_raddr;
  logic [SW-1:0]     lp_rdata;
  logic              prev_we;
  logic [CIDX_W-1:0] prev_raddr;
  logic [SW-1:0]     prev_wdata;
  logic [SW-1:0]     prev_rdata;

  logic signed [SW-1:0] lp_s;
  logic signed [SW-1:0] prev_s;
  logic signed [SW-1:0] cell_s;
  logic signed [SW-1:0] v_ext;
  logic signed [SW-1:0] left_base;
  logic signed [SW-1:0] left_next;
  logic signed [SW-1:0] right_base;
  logic signed [SW-1:0] right_next;
  logic signed [SW-1:0] merged;

  assign lp_s   = $signed(lp_rdata);
  assign prev_s = $signed(prev_rdata);
  assign cell_s = SW'($signed(cells_rdata));
  assign v_ext  = SW'(v_reg);

  // Left pass: best of the left neighbor and the cell above, plus this cell.
  always_comb begin
    if (first_row) begin
      left_base = (c_reg == '0) ? '0 : lp_s;
    end else if (c_reg == '0) begin
      left_base = prev_s;
    end else begin
      left_base = (lp_s > prev_s) ? lp_s : prev_s;
    end
  end
  assign left_next = left_base + v_ext;

  // Right pass: best of the right neighbor and the cell above, plus this cell.
  always_comb begin
    if (k == last_idx) begin
      right_base = prev_s;
    end else begin
      right_base = (right_reg > prev_s) ? right_reg : prev_s;
    end
  end
  assign right_next = right_base + cell_s;
  assign merged     = (lp_s > right_reg) ? lp_s : right_reg;

  // Store control for each operation.
  always_comb begin
    cells_we   = 1'b0;
    lp_we      = 1'b0;
    prev_we    = 1'b0;
    lp_raddr   = k;
    prev_raddr = k;
    prev_wdata = merged;
    unique case (op)
      gmps_pkg::OP_RD_LEFT: begin
        cells_we   = 1'b1;
        lp_raddr   = c_reg - CIDX_W'(1);
        prev_raddr = c_reg;
      end
      gmps_pkg::OP_LEFT: begin
        lp_we = 1'b1;
      end
      gmps_pkg::OP_C_WR: begin
        prev_we    = 1'b1;
        prev_wdata = lp_rdata;
      end
      gmps_pkg::OP_R_WR: begin
        prev_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  gmps_ram #(.WIDTH(VW), .DEPTH(MAX_COLS)) u_cells (
    .clk   (clk),
    .we    (cells_we),
    .waddr (c_reg),
    .wdata (v_reg),
    .raddr (k),
    .rdata (cells_rdata)
  );

  gmps_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_left_pass (
    .clk   (clk),
    .we    (lp_we),
    .waddr (c_reg),
    .wdata (left_next),
    .raddr (lp_raddr),
    .rdata (lp_rdata)
  );

  gmps_ram #(.WIDTH(SW), .DEPTH(MAX_COLS)) u_prev_row (
    .clk   (clk),
    .we    (prev_we),
    .waddr (k),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  // Grid position and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      column_index <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (op)
        gmps_pkg::OP_LEFT: begin
          if (!row_end) begin
            column_index <= c_reg + CIDX_W'(1);
          end
        end
        gmps_pkg::OP_ROW_NEXT: begin
          row_index    <= row_index + RIDX_W'(1);
          column_index <= '0;
        end
        gmps_pkg::OP_FINISH: begin
          row_index    <= '0;
          column_index <= '0;
          done         <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      v_reg     <= cell_value;
      c_reg     <= c_in;
      last_idx  <= CIDX_W'(eff_cols - CCNT_W'(1));
      row_end   <= (CCNT_W'(c_in) + CCNT_W'(1)) >= eff_cols;
      last_row  <= (RCNT_W'(row_index) + RCNT_W'(1)) >= eff_rows;
      first_row <= (row_index == '0);
    end
    unique case (op)
      gmps_pkg::OP_LEFT:   left_reg  <= left_next;
      gmps_pkg::OP_K_INIT: k         <= first_row ? '0 : last_idx;
      gmps_pkg::OP_R_SUM:  right_reg <= right_next;
      gmps_pkg::OP_C_WR: begin
        if (k != last_idx) begin
          k <= k + CIDX_W'(1);
        end
      end
      gmps_pkg::OP_R_WR: begin
        if (k != '0) begin
          k <= k - CIDX_W'(1);
        end
      end
      gmps_pkg::OP_FINISH: best_sum <= left_reg;
      default: begin
      end
    endcase
  end

  assign status.not_row_end = !row_end;
  assign status.last_row    = last_row;
  assign status.first_row   = first_row;
  assign status.k_up_more   = (k != last_idx);
  assign status.k_dn_more   = (k != '0);

endmodule

>>> rtl/grid_max_path_sum_lrd_core.sv
// ----------------------------------------------------------------------------
// Grid maximum path sum core
// Best left, right or down path sum over a grid streamed in row-major order.
// ----------------------------------------------------------------------------
// Cells are taken with start while busy is low, one word per cell. A cell
// that does not end a row runs these steps of the control program: read of
// the column stores, left-pass add and write, return to idle. A cell that
// ends the first row adds a read and a write per column for the copy into
// the row-best store; one that ends a later middle row adds the right-to-left
// pass, three steps per column for read, add and merge on the single read
// port of each store. The final cell of the grid gives best_sum with done
// high for exactly one cycle, after its read, left-pass, row-end and finish
// steps. The receiver cannot stall: done is a strobe, and best_sum holds its
// value until the next grid finishes. Configuration writes are always ready
// and should land only between grids or between cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_max_path_sum_lrd_core #(
  parameter int MAX_COLS = gmps_pkg::GMPS_MAX_COLS,
  parameter int MAX_ROWS = gmps_pkg::GMPS_MAX_ROWS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [gmps_pkg::CELL_W-1:0]   cell_value,
  output logic signed [gmps_pkg::SUM_W-1:0]    best_sum,
  output logic                                 done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gmps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gmps_pkg::CFG_W-1:0]           cfg_data
);

  logic [gmps_pkg::CFG_W-1:0] row_count;
  logic [gmps_pkg::CFG_W-1:0] column_count;
  gmps_pkg::status_t          status;
  gmps_pkg::op_t              op;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= gmps_pkg::CFG_W'(1);
      column_count <= gmps_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmps_pkg::CFG_ROW_COUNT:    row_count    <= cfg_data;
        gmps_pkg::CFG_COLUMN_COUNT: column_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gmps_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  gmps_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .start        (start),
    .cell_value   (cell_value),
    .row_count    (row_count),
    .column_count (column_count),
    .status       (status),
    .best_sum     (best_sum),
    .done         (done)
  );

  // The result strobe lands as the sequencer returns to idle, lasts one
  // cycle, and an accepted cell always makes the core busy.
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

endmodule

>>> dv/tb_grid_max_path_sum_lrd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maximum path sum core testbench
// Streams grids of cell words into the core under changing row and column
// counts and checks every best_sum word against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_grid_max_path_sum_lrd_core;
  import gmps_pkg::*;

  localparam int NCOLS    = GMPS_MAX_COLS;
  localparam int NROWS    = GMPS_MAX_ROWS;
  localparam int PLAN_LEN = 31;

  typedef enum logic {PLAN_CELL, PLAN_WRITE} plan_kind_t;

  typedef struct packed {
    plan_kind_t                kind;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_W-1:0]          reg_val;
    logic signed [CELL_W-1:0]  cell_val;
    logic                      known;
    logic signed [SUM_W-1:0]   known_sum;
  } plan_row_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [CELL_W-1:0] cell_value;
  logic signed [SUM_W-1:0]  best_sum;
  logic                     done;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  // Predictor copy of the registers and the column stores.
  logic [CFG_W-1:0]         rows_reg;
  logic [CFG_W-1:0]         cols_reg;
  logic signed [SUM_W-1:0]  prev_best [NCOLS];
  logic signed [CELL_W-1:0] row_val [NCOLS];
  logic signed [SUM_W-1:0]  left_best [NCOLS];
  int                       row_at;
  int                       col_at;

  logic signed [SUM_W-1:0]  pending_sums [$];
  logic signed [SUM_W-1:0]  sum_want;
  plan_row_t                plan [PLAN_LEN];
  int                       idle_pct;
  int                       failures;
  int                       cells_sent;
  int                       grids_done;
  int                       sums_checked;
  int                       reg_writes;
  int                       mid_changes;

  grid_max_path_sum_lrd_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cell_value (cell_value),
    .best_sum   (best_sum),
    .done       (done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Free-running clock, 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // A count of zero acts as one; anything above the store depth saturates.
  function automatic int clamp_count(input logic [CFG_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] bigger(input logic signed [SUM_W-1:0] a,
                                                     input logic signed [SUM_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Advances the predicted grid by one cell and reports a finished grid.
  task automatic advance_grid(input logic signed [CELL_W-1:0] v, output logic hit,
                              output logic signed [SUM_W-1:0] sum);
    int nr;
    int nc;
    int c;
    int k;
    logic signed [SUM_W-1:0] left;
    logic signed [SUM_W-1:0] right;
    nr = clamp_count(rows_reg, NROWS);
    nc = clamp_count(cols_reg, NCOLS);
    c = (col_at >= nc) ? nc - 1 : col_at;
    row_val[c] = v;
    if (row_at == 0) begin
      if (c == 0) left = v;
      else left = left_best[c-1] + v;
    end else if (c == 0) begin
      left = prev_best[0] + v;
    end else begin
      left = bigger(left_best[c-1], prev_best[c]) + v;
    end
    left_best[c] = left;
    hit = 1'b0;
    sum = '0;
    if (c + 1 < nc) begin
      col_at = c + 1;
    end else if (row_at + 1 >= nr) begin
      // Final cell of the grid: the left pass alone gives the answer.
      hit = 1'b1;
      sum = left;
      row_at = 0;
      col_at = 0;
    end else begin
      if (row_at == 0) begin
        for (k = 0; k < nc; k++) prev_best[k] = left_best[k];
      end else begin
        // Right-to-left pass, merged with the left pass column by column.
        right = '0;
        for (k = nc - 1; k >= 0; k--) begin
          if (k == nc - 1) right = prev_best[k] + row_val[k];
          else right = bigger(right, prev_best[k]) + row_val[k];
          prev_best[k] = bigger(left_best[k], right);
        end
      end
      row_at = row_at + 1;
      col_at = 0;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    failures++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Waits until the core is quiet, then writes one register.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (3 * clamp_count(cols_reg, NCOLS) + 8) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROW_COUNT) rows_reg = val;
    else if (idx == CFG_COLUMN_COUNT) cols_reg = val;
    reg_writes++;
    if (row_at != 0 || col_at != 0) mid_changes++;
  endtask

  // Offers one cell word, with random idle cycles ahead of it.
  task automatic push_cell(input logic signed [CELL_W-1:0] v, input logic known,
                           input logic signed [SUM_W-1:0] known_sum, output logic hit);
    logic signed [SUM_W-1:0] sum;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    cell_value <= v;
    do @(posedge clk); while (busy);
    advance_grid(v, hit, sum);
    cells_sent++;
    if (hit) begin
      pending_sums.push_back(known ? known_sum : sum);
      grids_done++;
    end
  endtask

  function automatic logic signed [CELL_W-1:0] pick_cell();
    int t;
    if ($urandom_range(3) == 0) return CELL_W'($urandom_range(255));
    t = int'($urandom_range(200)) - 100;
    return CELL_W'(t);
  endfunction

  function automatic logic [CFG_W-1:0] pick_count(input int top, input int wide);
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 10) return CFG_W'($urandom_range(top + 1, wide));
    return CFG_W'($urandom_range(1, top));
  endfunction

  function automatic plan_row_t cell_step(input int v);
    return '{kind: PLAN_CELL, reg_idx: '0, reg_val: '0, cell_val: CELL_W'(v),
             known: 1'b0, known_sum: '0};
  endfunction

  function automatic plan_row_t known_step(input int v, input int s);
    return '{kind: PLAN_CELL, reg_idx: '0, reg_val: '0, cell_val: CELL_W'(v),
             known: 1'b1, known_sum: SUM_W'(s)};
  endfunction

  function automatic plan_row_t write_step(input logic [CFG_IDX_W-1:0] idx, input int val);
    return '{kind: PLAN_WRITE, reg_idx: idx, reg_val: CFG_W'(val), cell_val: '0,
             known: 1'b0, known_sum: '0};
  endfunction

  // One random grid, sometimes with a count changed part way through.
  task automatic run_grid();
    logic hit;
    logic moved;
    write_register(CFG_ROW_COUNT, pick_count(5, 12));
    write_register(CFG_COLUMN_COUNT, pick_count(9, 40));
    moved = 1'b0;
    hit = 1'b0;
    while (!hit) begin
      if (!moved && (row_at != 0 || col_at != 0) && $urandom_range(29) == 0) begin
        // Widening is only safe in the first row; later rows may only narrow.
        moved = 1'b1;
        if (row_at == 0)
          write_register(CFG_COLUMN_COUNT, CFG_W'($urandom_range(1, 9)));
        else if ($urandom_range(1) == 0)
          write_register(CFG_ROW_COUNT, CFG_W'($urandom_range(1, 4)));
        else
          write_register(CFG_COLUMN_COUNT,
                         CFG_W'($urandom_range(1, clamp_count(cols_reg, NCOLS))));
      end
      push_cell(pick_cell(), 1'b0, '0, hit);
    end
  endtask

  // Result checker: done is a one-cycle strobe with no back-pressure.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_sums.size() == 0) begin
        flag_mismatch($sformatf("best_sum %0d with no grid pending", best_sum));
      end else begin
        sum_want = pending_sums.pop_front();
        sums_checked++;
        if (best_sum !== sum_want)
          flag_mismatch($sformatf("best_sum %0d, predicted %0d", best_sum, sum_want));
      end
    end
  end

  initial begin : stimulus
    int i;
    int phase;
    int phase_start;
    int n;
    logic hit;
    rst        <= 1'b1;
    start      <= 1'b0;
    cell_value <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    rows_reg = 1;
    cols_reg = 1;
    row_at = 0;
    col_at = 0;
    idle_pct = 12;
    failures = 0;
    cells_sent = 0;
    grids_done = 0;
    sums_checked = 0;
    reg_writes = 0;
    mid_changes = 0;
    for (i = 0; i < NCOLS; i++) begin
      prev_best[i] = '0;
      row_val[i]   = '0;
      left_best[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: single-cell grids at the value extremes, zero counts,
    // a full first row, narrowing mid-row, a middle row with a right pass,
    // and a row count cut below the current row.
    plan = '{
      known_step(127, 127), known_step(-128, -128),
      known_step(100, 100), known_step(-100, -100),
      write_step(CFG_ROW_COUNT, 0), write_step(CFG_COLUMN_COUNT, 0),
      known_step(55, 55),
      write_step(CFG_ROW_COUNT, 1), write_step(CFG_COLUMN_COUNT, 3),
      cell_step(100), cell_step(100), known_step(-128, 72),
      write_step(CFG_COLUMN_COUNT, 5), cell_step(50), cell_step(60),
      write_step(CFG_COLUMN_COUNT, 2), cell_step(7),
      write_step(CFG_ROW_COUNT, 3), write_step(CFG_COLUMN_COUNT, 2),
      cell_step(-50), cell_step(90), cell_step(30), cell_step(-1),
      cell_step(5), cell_step(5),
      write_step(CFG_ROW_COUNT, 4), write_step(CFG_COLUMN_COUNT, 1),
      cell_step(20), cell_step(-30),
      write_step(CFG_ROW_COUNT, 2), cell_step(9)
    };
    for (i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == PLAN_WRITE)
        write_register(plan[i].reg_idx, plan[i].reg_val);
      else
        push_cell(plan[i].cell_val, plan[i].known, plan[i].known_sum, hit);
    end

    // Random part in three pacing phases, each led by one large-count grid.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 59 : 0;
      case (phase)
        0: begin
          // Row count at its top code, cut short after a few rows.
          write_register(CFG_ROW_COUNT, CFG_W'(2047));
          write_register(CFG_COLUMN_COUNT, CFG_W'(2));
          n = $urandom_range(8, 20);
          repeat (2 * n) push_cell(pick_cell(), 1'b0, '0, hit);
          write_register(CFG_ROW_COUNT, CFG_W'($urandom_range(1, 3)));
        end
        1: begin
          // Full column depth, narrowed part way along the only row.
          write_register(CFG_ROW_COUNT, CFG_W'(1));
          write_register(CFG_COLUMN_COUNT, CFG_W'(NCOLS));
          n = $urandom_range(10, 30);
          repeat (n) push_cell(pick_cell(), 1'b0, '0, hit);
          write_register(CFG_COLUMN_COUNT, CFG_W'(n + $urandom_range(1, 4)));
        end
        default: begin
          // Column count at its top code, then cut to or below the column
          // reached so far, which ends the only row on the next cell.
          write_register(CFG_ROW_COUNT, CFG_W'(1));
          write_register(CFG_COLUMN_COUNT, CFG_W'(2047));
          n = $urandom_range(10, 30);
          repeat (n) push_cell(pick_cell(), 1'b0, '0, hit);
          write_register(CFG_COLUMN_COUNT, CFG_W'(n - $urandom_range(0, 4)));
        end
      endcase
      do push_cell(pick_cell(), 1'b0, '0, hit); while (!hit);
      phase_start = cells_sent;
      while (cells_sent - phase_start < 345 || (phase == 2 && grids_done < 60))
        run_grid();
    end

    // Drain the last results and let the core settle.
    start <= 1'b0;
    n = 0;
    while (pending_sums.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (16) @(posedge clk);
    if (pending_sums.size() != 0)
      flag_mismatch($sformatf("%0d best_sum words never arrived", pending_sums.size()));

    $display("Covered %0d cells in %0d grids, %0d best_sum words checked.",
             cells_sent, grids_done, sums_checked);
    $display("Made %0d register writes, %0d of them inside a grid, counts from 0 to 2047.",
             reg_writes, mid_changes);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #7_200_000;
    $display("Run timed out waiting on the core.");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gmps_pkg.sv
rtl/gmps_ram.sv
rtl/gmps_useq.sv
rtl/gmps_dp.sv
rtl/grid_max_path_sum_lrd_core.sv
dv/tb_grid_max_path_sum_lrd_core.sv
